// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define PPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define PPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ppr_pkg.sv -----
// Types and constants of the polyline point rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    // Coordinate width and derived widths
    localparam int COORD_BITS = 10;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;

    // Input word kinds carried on tuser
    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ERR_BITS-1:0]   err_t;

    // Walk directions: x steps down, y steps down, y is the major axis
    typedef struct packed {
        logic y_major;
        logic y_down;
        logic x_down;
    } step_dir_t;

    // One result word
    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        logic   segment_last;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/polyline_point_rasterizer_core.sv -----
// Top level of the polyline point rasterizer: Bresenham walk and output buffer.
`timescale 1ns / 1ps
`default_nettype none

// Joins a stream of points into a polyline and walks each segment with
// Bresenham's integer line algorithm. An input word with tuser = 0 carries a
// new point: the first one after reset returns a single dot marked last, later
// ones return an idle word (tuser = 0, tdata and tlast zero) and arm a segment
// from the new point back to the previous one. An input word with tuser = 1
// is a tick that returns the next pixel of the armed segment, tlast on its
// final pixel, or an idle word when no segment is armed. Every input word
// returns exactly one result word. The whole update (span, compare, one add and
// compare of the error term) sits between the state registers and the output
// register, so a word is accepted in every cycle while the skid word is empty,
// and its result is registered in the output or skid register. A two-word
// output buffer lets input continue for one word while the output side stalls.
module polyline_point_rasterizer_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Input channel
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [ppr_pkg::DATA_BITS-1:0] s_tdata,  // point_x, point_y
    input  wire  [0:0]                   s_tuser,   // mode
    // Result channel
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [ppr_pkg::DATA_BITS-1:0] m_tdata,  // pixel_x, pixel_y
    output logic [0:0]                   m_tuser,   // pixel_valid
    output logic                         m_tlast    // segment_last
);

    localparam int C = ppr_pkg::COORD_BITS;

    // Line state
    logic                 have_prev_reg, have_prev_next;
    ppr_pkg::coord_t      prev_x_reg, prev_x_next;
    ppr_pkg::coord_t      prev_y_reg, prev_y_next;
    logic                 walk_active_reg, walk_active_next;
    ppr_pkg::coord_t      walk_x_reg, walk_x_next;
    ppr_pkg::coord_t      walk_y_reg, walk_y_next;
    ppr_pkg::err_t        err_reg, err_next;
    ppr_pkg::coord_t      major_reg, major_next;
    ppr_pkg::coord_t      minor_reg, minor_next;
    ppr_pkg::err_t        left_reg, left_next;
    ppr_pkg::step_dir_t   dir_reg, dir_next;

    // Output buffer
    logic                 out_valid_reg, out_valid_next;
    ppr_pkg::result_t     out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    ppr_pkg::result_t     skid_data_reg, skid_data_next;

    logic                 s_accept;
    logic                 in_mode;
    ppr_pkg::coord_t      in_x, in_y;
    ppr_pkg::result_t     result;

    // Segment setup terms
    ppr_pkg::coord_t      dx, dy, st_major, st_minor;
    ppr_pkg::step_dir_t   st_dir;

    // Walk advance terms
    ppr_pkg::err_t        err_sum, err_adv;
    logic                 minor_step;
    ppr_pkg::err_t        left_dec;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign in_mode  = s_tuser[0];
    assign in_x     = s_tdata[C-1:0];
    assign in_y     = s_tdata[2*C-1:C];

    // Spans and directions of a segment from the new point back to the previous
    assign dx = (prev_x_reg >= in_x) ? (prev_x_reg - in_x) : (in_x - prev_x_reg);
    assign dy = (prev_y_reg >= in_y) ? (prev_y_reg - in_y) : (in_y - prev_y_reg);
    assign st_dir.x_down  = prev_x_reg < in_x;
    assign st_dir.y_down  = prev_y_reg < in_y;
    assign st_dir.y_major = dy > dx;
    assign st_major = st_dir.y_major ? dy : dx;
    assign st_minor = st_dir.y_major ? dx : dy;

    // Error term update for one step
    assign err_sum    = err_reg + {1'b0, minor_reg};
    assign minor_step = err_sum >= {1'b0, major_reg};
    assign err_adv    = minor_step ? (err_sum - {1'b0, major_reg}) : err_sum;
    assign left_dec   = left_reg - ppr_pkg::ERR_BITS'(1);

    // Next line state and result for the accepted word
    always_comb begin
        have_prev_next   = have_prev_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        walk_active_next = walk_active_reg;
        walk_x_next      = walk_x_reg;
        walk_y_next      = walk_y_reg;
        err_next         = err_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        left_next        = left_reg;
        dir_next         = dir_reg;
        result           = '0;
        if (s_accept) begin
            if (in_mode == ppr_pkg::MODE_POINT) begin
                walk_active_next = 1'b0;
                if (!have_prev_reg) begin
                    result.pixel_valid  = 1'b1;
                    result.pixel_x      = in_x;
                    result.pixel_y      = in_y;
                    result.segment_last = 1'b1;
                    have_prev_next      = 1'b1;
                end else begin
                    dir_next         = st_dir;
                    major_next       = st_major;
                    minor_next       = st_minor;
                    err_next         = {1'b0, st_major >> 1};
                    left_next        = {1'b0, st_major} + ppr_pkg::ERR_BITS'(1);
                    walk_x_next      = in_x;
                    walk_y_next      = in_y;
                    walk_active_next = 1'b1;
                end
                prev_x_next = in_x;
                prev_y_next = in_y;
            end else if (walk_active_reg && (left_reg != '0)) begin
                result.pixel_valid  = 1'b1;
                result.pixel_x      = walk_x_reg;
                result.pixel_y      = walk_y_reg;
                result.segment_last = (left_reg == ppr_pkg::ERR_BITS'(1));
                left_next           = left_dec;
                if (left_dec == '0) begin
                    walk_active_next = 1'b0;
                end else begin
                    // Advance along the major axis, and the minor one on overflow
                    err_next = err_adv;
                    if (dir_reg.y_major) begin
                        walk_y_next = dir_reg.y_down ? (walk_y_reg - C'(1))
                                                     : (walk_y_reg + C'(1));
                        if (minor_step) begin
                            walk_x_next = dir_reg.x_down ? (walk_x_reg - C'(1))
                                                         : (walk_x_reg + C'(1));
                        end
                    end else begin
                        walk_x_next = dir_reg.x_down ? (walk_x_reg - C'(1))
                                                     : (walk_x_reg + C'(1));
                        if (minor_step) begin
                            walk_y_next = dir_reg.y_down ? (walk_y_reg - C'(1))
                                                         : (walk_y_reg + C'(1));
                        end
                    end
                end
            end else begin
                walk_active_next = 1'b0;
            end
        end
    end

    // Output register with one skid word behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = s_accept;
                out_data_next  = result;
            end
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg   <= 1'b0;
            walk_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            have_prev_reg   <= have_prev_next;
            walk_active_reg <= walk_active_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        walk_x_reg    <= walk_x_next;
        walk_y_reg    <= walk_y_next;
        err_reg       <= err_next;
        major_reg     <= major_next;
        minor_reg     <= minor_next;
        left_reg      <= left_next;
        dir_reg       <= dir_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = ppr_pkg::DATA_BITS'({out_data_reg.pixel_y, out_data_reg.pixel_x});
    assign m_tuser[0] = out_data_reg.pixel_valid;
    assign m_tlast    = out_data_reg.segment_last;

endmodule

`default_nettype wire

// ----- hw/rtl/ppr_checker.sv -----
// Port-level checker for the polyline point rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppr_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [ppr_pkg::DATA_BITS-1:0] s_tdata,   // point_x, point_y
    input wire [0:0]                    s_tuser,   // mode
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [ppr_pkg::DATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y
    input wire [0:0]                    m_tuser,   // pixel_valid
    input wire                          m_tlast    // segment_last
);

    logic [2:0] pending_reg, pending_next;
    logic       in_word, out_word;
    logic       idle_word_clean;

    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;
    assign idle_word_clean = (m_tdata == '0) && !m_tlast;

    // Count words accepted but not yet delivered
    always_comb begin
        pending_next = pending_reg;
        if (in_word && !out_word) begin
            pending_next = pending_reg + 3'd1;
        end else if (!in_word && out_word) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Hold a stalled result word
    `PPR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")
    // Never show a result without an outstanding input word
    `PPR_ASSERT(a_no_invent, aclk, aresetn, (pending_reg == 3'd0) |-> !m_tvalid, "result word without input word")
    // Never hold more words than the output buffer has room for
    `PPR_ASSERT(a_buffer_bound, aclk, aresetn, (pending_reg == 3'd2) |-> !s_tready, "input taken with full buffer")
    // Idle result words carry zero payload
    `PPR_ASSERT(a_idle_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> idle_word_clean, "idle word with payload")

endmodule

bind polyline_point_rasterizer_core ppr_checker u_ppr_checker (.*);

`default_nettype wire
